>>> design/instrument_command_decoder_unit_assert.svh
// Assertion macros used by the decode stage of the instrument command decoder RTL.
`ifndef INSTRUMENT_COMMAND_DECODER_UNIT_ASSERT_SVH
`define INSTRUMENT_COMMAND_DECODER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge out of reset.
`define ICD_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");
// Check a consequence in the cycle after its cause.
`define ICD_ASSERT_NEXT(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("%m: assertion failed");
`else
`define ICD_ASSERT_ALWAYS(label, clk, rst, expr)
`define ICD_ASSERT_NEXT(label, clk, rst, cause, effect)
`endif
`endif

>>> design/icd_pkg.sv
// Types, constants and helpers of the instrument command decoder.
`default_nettype none
package icd_pkg;

   localparam int PLATE_COLUMNS = 12;
   localparam int REAGENT_SLOTS = 12;
   localparam int SHAKE_LIMIT   = 60;

   localparam int REQ_WIDTH = 32;
   localparam int RSP_WIDTH = 40;

   // ASCII codes used by the decoder
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_M     = 8'h4D;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_Q     = 8'h51;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_Z     = 8'h5A;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_ENTER = 3'd1,
      CMD_QUIT  = 3'd2,
      CMD_SCAN  = 3'd3,
      CMD_CFG   = 3'd4,
      CMD_DATE  = 3'd5,
      CMD_SN    = 3'd6,
      CMD_VER   = 3'd7
   } cmd_type;

   // Input word, lowest field last
   typedef struct packed {
      logic [1:0] pad;
      logic [7:0] third_char;
      logic [7:0] second_char;
      logic [7:0] first_char;
      logic [5:0] frame_length;
   } req_word_type;

   // Kept scan options
   typedef struct packed {
      logic [3:0] reagent_count;
      logic       reagent_mode;
      logic [6:0] shake_time;
      logic [1:0] shake_speed;
      logic       step_mode;
      logic [2:0] wavelength;
      logic [3:0] column_count;
      logic [3:0] start_column;
      logic [6:0] scan_count;
   } options_type;

   // Result word, lowest field last
   typedef struct packed {
      logic [3:0]  reagent_written;
      options_type options;
      cmd_type     command;
   } rsp_word_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_nz_digit(input logic [7:0] c);
      return (c >= CHAR_ONE) && (c <= CHAR_NINE);
   endfunction

endpackage
`default_nettype wire

>>> design/instrument_command_decoder_unit.sv
// A word accepted into the input register passes through the decode logic into
// the result register when that register can take it, and is offered from there.
// Throughput: one word per cycle while the result side is not stalled, set by the
// single decode stage between the input register and the result register.
// Reset (synchronous, active high) empties both registers and restores the
// scan options: one scan, start column 0, 12 columns, all else zero.
`default_nettype none
module instrument_command_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // frame_length[5:0], first_char[13:6], second_char[21:14], third_char[29:22]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // command[2:0], scan_count[9:3], start_column[13:10], column_count[17:14],
   // wavelength[20:18], step_mode[21], shake_speed[23:22], shake_time[30:24],
   // reagent_mode[31], reagent_count[35:32], reagent_written[39:36]
   output logic [39:0]      rsp_tdata
);

   logic                  out_can;
   logic                  fire;
   icd_pkg::req_word_type word;
   icd_pkg::rsp_word_type rsp_next;

   icd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_can    (out_can),
      .fire       (fire),
      .word       (word)
   );

   icd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .word     (word),
      .rsp_next (rsp_next)
   );

   icd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .rsp_in     (rsp_next),
      .out_can    (out_can),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> design/icd_in_stage.sv
// Input register of the instrument command decoder.
`default_nettype none
module icd_in_stage (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [icd_pkg::REQ_WIDTH-1:0] req_tdata,
   input  wire logic                       out_can,
   output logic                            fire,
   output icd_pkg::req_word_type           word
);

   logic                  valid_ff;
   logic                  valid_in;
   icd_pkg::req_word_type word_ff;
   logic                  load;

   // Take a word when the stage is empty or moves on this cycle
   assign fire       = valid_ff && out_can;
   assign req_tready = !valid_ff || out_can;
   assign load       = req_tvalid && req_tready;
   assign word       = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the next word is loaded
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= icd_pkg::req_word_type'(req_tdata);
      end
   end

endmodule
`default_nettype wire

>>> design/icd_decode.sv
// Command decode and kept scan options of the instrument command decoder.
`default_nettype none
`include "instrument_command_decoder_unit_assert.svh"
module icd_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire icd_pkg::req_word_type word,
   output icd_pkg::rsp_word_type rsp_next
);

   icd_pkg::options_type opts_ff;
   icd_pkg::options_type opts_in;
   icd_pkg::cmd_type     cmd;
   logic [3:0]           written;
   logic                 len1;
   logic                 len2;
   logic                 len3;
   logic [7:0]           c1;
   logic [7:0]           c2;
   logic [3:0]           d1;
   logic [3:0]           d2;
   logic [6:0]           n2;
   logic [6:0]           b_n;
   logic                 b_ok;

   // Mask characters past the frame length and form digit values
   always_comb begin
      len1 = (word.frame_length == 6'd1);
      len2 = (word.frame_length == 6'd2);
      len3 = (word.frame_length == 6'd3);
      c1   = (word.frame_length < 6'd2) ? 8'd0 : word.second_char;
      c2   = (word.frame_length < 6'd3) ? 8'd0 : word.third_char;
      d1   = 4'(c1 - icd_pkg::CHAR_ZERO);
      d2   = 4'(c2 - icd_pkg::CHAR_ZERO);
      n2   = 7'(7'(d1) * 7'd10) + 7'(d2);
   end

   // Pick the reagent column of a B command
   always_comb begin
      b_n = 7'(icd_pkg::PLATE_COLUMNS);
      if (len2 && icd_pkg::is_nz_digit(c1)) begin
         b_n = 7'(d1) - 7'd1;
      end else if (len3 && icd_pkg::is_nz_digit(c1) && icd_pkg::is_digit(c2)) begin
         b_n = n2 - 7'd1;
      end
      b_ok = (b_n < 7'(icd_pkg::PLATE_COLUMNS));
   end

   // Decode the command letter and update the options
   always_comb begin
      opts_in = opts_ff;
      cmd     = icd_pkg::CMD_NONE;
      written = 4'd0;
      if (word.frame_length != 6'd0) begin
         unique case (word.first_char)
            icd_pkg::CHAR_R: if (len1) cmd = icd_pkg::CMD_ENTER;
            icd_pkg::CHAR_Q: if (len1) cmd = icd_pkg::CMD_QUIT;
            icd_pkg::CHAR_T: if (len1) cmd = icd_pkg::CMD_DATE;
            icd_pkg::CHAR_N: if (len1) cmd = icd_pkg::CMD_SN;
            icd_pkg::CHAR_V: if (len1) cmd = icd_pkg::CMD_VER;
            icd_pkg::CHAR_P: begin
               if (len1) begin
                  opts_in.scan_count = 7'd1;
                  cmd = icd_pkg::CMD_SCAN;
               end else if (len2 && c1 == icd_pkg::CHAR_M) begin
                  opts_in.scan_count = 7'd1;
               end else if (icd_pkg::is_digit(c1)) begin
                  if (len2) begin
                     opts_in.scan_count = 7'(d1);
                     cmd = icd_pkg::CMD_SCAN;
                  end else if (len3 && icd_pkg::is_digit(c2)) begin
                     opts_in.scan_count = n2;
                     cmd = icd_pkg::CMD_SCAN;
                  end
               end
            end
            icd_pkg::CHAR_M: begin
               if (len2 && icd_pkg::is_nz_digit(c1)) begin
                  if (7'(d1) <= 7'(icd_pkg::PLATE_COLUMNS)) begin
                     opts_in.start_column = d1 - 4'd1;
                     cmd = icd_pkg::CMD_SCAN;
                  end
               end else if (len3 && icd_pkg::is_digit(c2)) begin
                  if (icd_pkg::is_digit(c1) && n2 >= 7'd1 &&
                      n2 <= 7'(icd_pkg::PLATE_COLUMNS)) begin
                     opts_in.start_column = 4'(n2 - 7'd1);
                     cmd = icd_pkg::CMD_SCAN;
                  end else begin
                     opts_in.start_column = 4'd0;
                  end
               end
            end
            icd_pkg::CHAR_F: begin
               if (c1 >= icd_pkg::CHAR_ONE && c1 <= icd_pkg::CHAR_EIGHT) begin
                  opts_in.wavelength = 3'(c1 - icd_pkg::CHAR_ONE);
                  cmd = icd_pkg::CMD_CFG;
               end
            end
            icd_pkg::CHAR_E: begin
               if (c1 == icd_pkg::CHAR_ZERO) begin
                  opts_in.step_mode = 1'b0;
                  cmd = icd_pkg::CMD_CFG;
               end else if (c1 == icd_pkg::CHAR_ONE) begin
                  opts_in.step_mode = 1'b1;
                  cmd = icd_pkg::CMD_CFG;
               end
            end
            icd_pkg::CHAR_X: begin
               if (len2 && c1 >= icd_pkg::CHAR_ONE && c1 <= icd_pkg::CHAR_THREE) begin
                  opts_in.shake_speed = 2'(c1 - icd_pkg::CHAR_ONE);
                  cmd = icd_pkg::CMD_CFG;
               end
            end
            icd_pkg::CHAR_Z: begin
               if (len2 && icd_pkg::is_digit(c1)) begin
                  opts_in.shake_time = 7'(d1);
                  cmd = icd_pkg::CMD_SCAN;
               end else if (len3 && icd_pkg::is_digit(c2)) begin
                  if (icd_pkg::is_digit(c1) && n2 <= 7'(icd_pkg::SHAKE_LIMIT)) begin
                     opts_in.shake_time = n2;
                     cmd = icd_pkg::CMD_CFG;
                  end else begin
                     opts_in.shake_time = 7'd0;
                  end
               end
            end
            icd_pkg::CHAR_A: begin
               if (len1) begin
                  opts_in.reagent_mode  = 1'b0;
                  opts_in.reagent_count = 4'd0;
                  cmd = icd_pkg::CMD_CFG;
               end
            end
            icd_pkg::CHAR_B: begin
               // drop the entry once the list is full
               if (opts_ff.reagent_count < 4'(icd_pkg::REAGENT_SLOTS) && b_ok) begin
                  written               = b_n[3:0];
                  opts_in.reagent_count = opts_ff.reagent_count + 4'd1;
                  opts_in.reagent_mode  = 1'b1;
                  cmd = icd_pkg::CMD_CFG;
               end
            end
            default: ;
         endcase
      end
      // Scan commands refresh the column count from the new start column
      if (cmd == icd_pkg::CMD_SCAN) begin
         opts_in.column_count =
            (opts_in.start_column < 4'(icd_pkg::PLATE_COLUMNS)) ?
            4'(icd_pkg::PLATE_COLUMNS) - opts_in.start_column : 4'd0;
      end
   end

   always_comb begin
      rsp_next.command         = cmd;
      rsp_next.options         = opts_in;
      rsp_next.reagent_written = written;
   end

   // Advance the options once per decoded word
   always_ff @(posedge clock) begin
      if (reset) begin
         opts_ff.scan_count    <= 7'd1;
         opts_ff.start_column  <= 4'd0;
         opts_ff.column_count  <= 4'(icd_pkg::PLATE_COLUMNS);
         opts_ff.wavelength    <= 3'd0;
         opts_ff.step_mode     <= 1'b0;
         opts_ff.shake_speed   <= 2'd0;
         opts_ff.shake_time    <= 7'd0;
         opts_ff.reagent_mode  <= 1'b0;
         opts_ff.reagent_count <= 4'd0;
      end else if (fire) begin
         opts_ff <= opts_in;
      end
   end

   `ICD_ASSERT_ALWAYS(a_count_bound, clock, reset,
      opts_ff.reagent_count <= 4'(icd_pkg::REAGENT_SLOTS))
   `ICD_ASSERT_ALWAYS(a_start_bound, clock, reset,
      opts_ff.start_column < 4'(icd_pkg::PLATE_COLUMNS))
   `ICD_ASSERT_NEXT(a_scan_cols, clock, reset, fire && cmd == icd_pkg::CMD_SCAN,
      opts_ff.column_count == 4'(icd_pkg::PLATE_COLUMNS) - opts_ff.start_column)
   `ICD_ASSERT_NEXT(a_add_reagent, clock, reset, fire && written != 4'd0,
      opts_ff.reagent_mode && opts_ff.reagent_count == $past(opts_ff.reagent_count) + 4'd1)

endmodule
`default_nettype wire

>>> design/icd_out_stage.sv
// Result register of the instrument command decoder.
`default_nettype none
module icd_out_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire icd_pkg::rsp_word_type         rsp_in,
   output logic                               out_can,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [icd_pkg::RSP_WIDTH-1:0]      rsp_tdata
);

   logic                  valid_ff;
   logic                  valid_in;
   icd_pkg::rsp_word_type data_ff;

   // Free when empty or when the waiting word is taken now
   assign out_can    = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = icd_pkg::RSP_WIDTH'(data_ff);

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire
